// ===== design/bsi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box/sphere intersection package
// Shared widths, mode codes and pipeline control type for the box/sphere
// intersection test.
// ----------------------------------------------------------------------------
package bsi_pkg;

    // Field widths.
    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;
    localparam int RAD_W    = 32;
    localparam int DIFF_W   = 33;
    localparam int CMP_W    = 34;
    localparam int SQ_W     = 64;
    localparam int SUM_W    = 66;
    localparam int MODE_W   = 2;
    localparam int NUM_AXES = 3;

    // Pipeline depth, including the output register.
    localparam int NUM_STAGES = 6;

    // Mode codes: box shape first, sphere shape second.
    localparam logic [MODE_W-1:0] MODE_HOLLOW_HOLLOW = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HOLLOW_SOLID  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SOLID_HOLLOW  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SOLID_SOLID   = 2'd3;

    // Per-stage advance enables shared by the control and the axis lanes.
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctl;

endpackage

// ===== design/bsi_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Query channel
// Valid/ready channel that carries one box, sphere and mode per beat.
// ----------------------------------------------------------------------------
interface bsi_in_if import bsi_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  box_min_x;
    logic signed [COORD_W-1:0]  box_min_y;
    logic signed [COORD_W-1:0]  box_min_z;
    logic signed [COORD_W-1:0]  box_max_x;
    logic signed [COORD_W-1:0]  box_max_y;
    logic signed [COORD_W-1:0]  box_max_z;
    logic signed [COORD_W-1:0]  center_x;
    logic signed [COORD_W-1:0]  center_y;
    logic signed [COORD_W-1:0]  center_z;
    logic        [RADIUS_W-1:0] radius;
    logic        [MODE_W-1:0]   command;

    modport source (
        output valid, box_min_x, box_min_y, box_min_z,
               box_max_x, box_max_y, box_max_z,
               center_x, center_y, center_z, radius, command,
        input  ready
    );

    modport sink (
        input  valid, box_min_x, box_min_y, box_min_z,
               box_max_x, box_max_y, box_max_z,
               center_x, center_y, center_z, radius, command,
        output ready
    );

endinterface

// ===== design/bsi_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one intersection flag per beat.
// ----------------------------------------------------------------------------
interface bsi_out_if import bsi_pkg::*; ();

    logic valid;
    logic ready;
    logic intersects;

    modport source (
        output valid, intersects,
        input  ready
    );

    modport sink (
        input  valid, intersects,
        output ready
    );

endinterface

// ===== design/bsi_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box/sphere axis lane
// Stages one to four for one axis: plane distances, magnitudes, squares,
// and the per-axis terms for the near and far distance sums.
// ----------------------------------------------------------------------------
module bsi_axis import bsi_pkg::*; (
    input  logic                      i_clk,
    input  t_pipe_ctl                 i_ctl,
    input  logic signed [COORD_W-1:0] i_c,
    input  logic signed [COORD_W-1:0] i_bmin,
    input  logic signed [COORD_W-1:0] i_bmax,
    input  logic        [RAD_W-1:0]   i_rad_s1,
    input  logic        [MODE_W-1:0]  i_mode_s3,
    input  logic        [SQ_W-1:0]    i_rsq_s3,
    output logic        [SQ_W-1:0]    o_max_sq,
    output logic        [SQ_W-1:0]    o_dmin_sq,
    output logic                      o_face
);

    // Stage 1 registers.
    logic signed [DIFF_W-1:0] r_d;
    logic signed [DIFF_W-1:0] r_e;
    logic                     r_below_s1;
    logic                     r_above_s1;
    // Stage 2 registers.
    logic [COORD_W-1:0]       r_abs_d;
    logic [COORD_W-1:0]       r_abs_e;
    logic                     r_lin_s2;
    logic                     r_below_s2;
    logic                     r_above_s2;
    // Stage 3 registers.
    logic [SQ_W-1:0]          r_a;
    logic [SQ_W-1:0]          r_b;
    logic                     r_lin_s3;
    logic                     r_below_s3;
    logic                     r_above_s3;
    // Stage 4 registers.
    logic [SQ_W-1:0]          r_max_sq;
    logic [SQ_W-1:0]          r_dmin_sq;
    logic                     r_face;

    logic signed [DIFF_W-1:0] n_d;
    logic signed [DIFF_W-1:0] n_e;
    logic                     n_below;
    logic                     n_above;
    logic [DIFF_W-1:0]        n_abs_d;
    logic [DIFF_W-1:0]        n_abs_e;
    logic signed [CMP_W-1:0]  n_gap_lo;
    logic signed [CMP_W-1:0]  n_gap_hi;
    logic signed [CMP_W-1:0]  n_rad_cmp;
    logic                     n_lin;
    logic [SQ_W-1:0]          n_min_ab;
    logic                     n_face;

    // Stage 1: signed distances to both planes and slab position.
    always_comb begin
        n_d     = {i_c[COORD_W-1], i_c} - {i_bmin[COORD_W-1], i_bmin};
        n_e     = {i_c[COORD_W-1], i_c} - {i_bmax[COORD_W-1], i_bmax};
        n_below = i_c < i_bmin;
        n_above = !n_below && (i_c > i_bmax);
    end

    // Stage 2: magnitudes, and the linear gap test against the radius.
    always_comb begin
        n_abs_d   = r_d[DIFF_W-1] ? DIFF_W'(-r_d) : DIFF_W'(r_d);
        n_abs_e   = r_e[DIFF_W-1] ? DIFF_W'(-r_e) : DIFF_W'(r_e);
        n_gap_lo  = {r_d[DIFF_W-1], r_d};
        n_gap_hi  = -{r_e[DIFF_W-1], r_e};
        n_rad_cmp = {2'b00, i_rad_s1};
        n_lin     = (n_gap_lo <= n_rad_cmp) || (n_gap_hi <= n_rad_cmp);
    end

    // Stage 4: far term, near term and face flag for this axis.
    always_comb begin
        n_min_ab = (r_a < r_b) ? r_a : r_b;
        n_face   = r_below_s3 || r_above_s3
                   || ((i_mode_s3 == MODE_HOLLOW_HOLLOW) && (n_min_ab <= i_rsq_s3))
                   || ((i_mode_s3 == MODE_HOLLOW_SOLID) && r_lin_s3);
    end

    // Datapath registers advance with their stage enables.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_d        <= n_d;
            r_e        <= n_e;
            r_below_s1 <= n_below;
            r_above_s1 <= n_above;
        end
        if (i_ctl.en[1]) begin
            r_abs_d    <= n_abs_d[COORD_W-1:0];
            r_abs_e    <= n_abs_e[COORD_W-1:0];
            r_lin_s2   <= n_lin;
            r_below_s2 <= r_below_s1;
            r_above_s2 <= r_above_s1;
        end
        if (i_ctl.en[2]) begin
            r_a        <= {{COORD_W{1'b0}}, r_abs_d} * {{COORD_W{1'b0}}, r_abs_d};
            r_b        <= {{COORD_W{1'b0}}, r_abs_e} * {{COORD_W{1'b0}}, r_abs_e};
            r_lin_s3   <= r_lin_s2;
            r_below_s3 <= r_below_s2;
            r_above_s3 <= r_above_s2;
        end
        if (i_ctl.en[3]) begin
            r_max_sq   <= (r_a > r_b) ? r_a : r_b;
            r_dmin_sq  <= r_below_s3 ? r_a : (r_above_s3 ? r_b : '0);
            r_face     <= n_face;
        end
    end

    assign o_max_sq  = r_max_sq;
    assign o_dmin_sq = r_dmin_sq;
    assign o_face    = r_face;

endmodule

// ===== design/box_sphere_intersection_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box/sphere intersection test
// Decides whether an axis-aligned box and a sphere intersect, each treated
// as hollow or solid, with exact fixed-point distance sums.
// ----------------------------------------------------------------------------
// Throughput: one query per cycle unless the result channel stalls; each
// of the six register stages holds one item and moves up whenever the
// stage after it is empty or moving; a result beat leaves the sixth stage.
// Reset (synchronous, active low) empties the pipeline and clears
// radius_epsilon to zero.
// ----------------------------------------------------------------------------
module box_sphere_intersection_test import bsi_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [RADIUS_W-1:0] i_cfg_wdata,
    bsi_in_if.sink              i_in,
    bsi_out_if.source           o_out
);

    logic [RADIUS_W-1:0]   r_radius_epsilon;
    logic [NUM_STAGES-1:0] r_v;
    t_pipe_ctl             w_ctl;

    logic [RAD_W-1:0]      r_rad_s1;
    logic [RAD_W-1:0]      r_rad_s2;
    logic [SQ_W-1:0]       r_rsq_s3;
    logic [SQ_W-1:0]       r_rsq_s4;
    logic [SQ_W-1:0]       r_rsq_s5;
    logic [MODE_W-1:0]     r_mode_s1;
    logic [MODE_W-1:0]     r_mode_s2;
    logic [MODE_W-1:0]     r_mode_s3;
    logic [MODE_W-1:0]     r_mode_s4;
    logic [MODE_W-1:0]     r_mode_s5;
    logic [SUM_W-1:0]      r_dmin_sum;
    logic [SUM_W-1:0]      r_dmax_sum;
    logic                  r_face;
    logic                  r_hit;

    logic signed [COORD_W-1:0] w_c    [NUM_AXES];
    logic signed [COORD_W-1:0] w_bmin [NUM_AXES];
    logic signed [COORD_W-1:0] w_bmax [NUM_AXES];
    logic [SQ_W-1:0]           w_max_sq  [NUM_AXES];
    logic [SQ_W-1:0]           w_dmin_sq [NUM_AXES];
    logic [NUM_AXES-1:0]       w_face;

    logic                  n_dmin_ok;
    logic                  n_dmax_ok;
    logic                  n_hit;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_epsilon <= '0;
        end else if (i_cfg_we) begin
            r_radius_epsilon <= i_cfg_wdata;
        end
    end

    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        w_ctl.en[NUM_STAGES-1] = !r_v[NUM_STAGES-1] || o_out.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_ctl.en[k] = !r_v[k] || w_ctl.en[k+1];
        end
    end

    assign i_in.ready = w_ctl.en[0];

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_ctl.en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_ctl.en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Per-axis lanes for stages one to four.
    assign w_c[0]    = i_in.center_x;
    assign w_c[1]    = i_in.center_y;
    assign w_c[2]    = i_in.center_z;
    assign w_bmin[0] = i_in.box_min_x;
    assign w_bmin[1] = i_in.box_min_y;
    assign w_bmin[2] = i_in.box_min_z;
    assign w_bmax[0] = i_in.box_max_x;
    assign w_bmax[1] = i_in.box_max_y;
    assign w_bmax[2] = i_in.box_max_z;

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
        bsi_axis u_axis (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_c       (w_c[g]),
            .i_bmin    (w_bmin[g]),
            .i_bmax    (w_bmax[g]),
            .i_rad_s1  (r_rad_s1),
            .i_mode_s3 (r_mode_s3),
            .i_rsq_s3  (r_rsq_s3),
            .o_max_sq  (w_max_sq[g]),
            .o_dmin_sq (w_dmin_sq[g]),
            .o_face    (w_face[g])
        );
    end

    // Final compares and mode selection.
    always_comb begin
        n_dmin_ok = r_dmin_sum <= {2'b00, r_rsq_s5};
        n_dmax_ok = {2'b00, r_rsq_s5} <= r_dmax_sum;
        unique case (r_mode_s5)
            MODE_HOLLOW_HOLLOW: n_hit = r_face && n_dmin_ok && n_dmax_ok;
            MODE_HOLLOW_SOLID:  n_hit = r_face && n_dmin_ok;
            MODE_SOLID_HOLLOW:  n_hit = n_dmin_ok && n_dmax_ok;
            MODE_SOLID_SOLID:   n_hit = n_dmin_ok;
            default:            n_hit = 1'b0;
        endcase
    end

    // Shared radius path, distance sums and the result register.
    always_ff @(posedge i_clk) begin
        if (w_ctl.en[0]) begin
            r_rad_s1  <= {1'b0, i_in.radius} + {1'b0, r_radius_epsilon};
            r_mode_s1 <= i_in.command;
        end
        if (w_ctl.en[1]) begin
            r_rad_s2  <= r_rad_s1;
            r_mode_s2 <= r_mode_s1;
        end
        if (w_ctl.en[2]) begin
            r_rsq_s3  <= {{RAD_W{1'b0}}, r_rad_s2} * {{RAD_W{1'b0}}, r_rad_s2};
            r_mode_s3 <= r_mode_s2;
        end
        if (w_ctl.en[3]) begin
            r_rsq_s4  <= r_rsq_s3;
            r_mode_s4 <= r_mode_s3;
        end
        if (w_ctl.en[4]) begin
            r_dmin_sum <= {2'b00, w_dmin_sq[0]} + {2'b00, w_dmin_sq[1]}
                          + {2'b00, w_dmin_sq[2]};
            r_dmax_sum <= {2'b00, w_max_sq[0]} + {2'b00, w_max_sq[1]}
                          + {2'b00, w_max_sq[2]};
            r_face     <= |w_face;
            r_rsq_s5   <= r_rsq_s4;
            r_mode_s5  <= r_mode_s4;
        end
        if (w_ctl.en[5]) begin
            r_hit <= n_hit;
        end
    end

    assign o_out.valid      = r_v[NUM_STAGES-1];
    assign o_out.intersects = r_hit;

    // An empty output stage lets the whole pipeline advance.
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NUM_STAGES-1] |-> i_in.ready)
        else $error("query channel stalled with an empty output stage");

    // A beat taken in with none sent out adds exactly one item in flight.
    a_item_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_in.valid && i_in.ready && !(o_out.valid && o_out.ready))
        |=> ($countones(r_v) == $past($countones(r_v)) + 1))
        else $error("accepted beat lost in the pipeline");

    // A beat sent out with none taken in removes exactly one item.
    a_item_count_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !(i_in.valid && i_in.ready) && o_out.valid && o_out.ready)
        |=> ($countones(r_v) + 1 == $past($countones(r_v))))
        else $error("result beat repeated or invented by the pipeline");

endmodule

// ===== test/box_sphere_intersection_test_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box/sphere intersection testbench
// Sends boxes, spheres and modes through the query channel while both sides
// of the block idle at random. Every accepted beat is scored against an
// independent fixed-point intersection calculation, which keeps its own copy
// of the radius margin. The run steps through several margins, including
// zero and full scale. It includes one long receiver hold-off that fills the
// pipeline and stalls the input.
// ----------------------------------------------------------------------------
module box_sphere_intersection_test_tb;
    import bsi_pkg::*;

    localparam int  STALL_LIMIT = 2000;
    localparam int  SHOWN_MAX   = 10;
    localparam longint ONE      = 64'h1_0000;
    localparam longint MIN_C    = -64'sh8000_0000;
    localparam longint MAX_C    = 64'sh7FFF_FFFF;
    localparam longint MAX_R    = 64'h7FFF_FFFF;

    localparam logic [MODE_W-1:0] ALL_MODES [4] = '{
        MODE_HOLLOW_HOLLOW, MODE_HOLLOW_SOLID, MODE_SOLID_HOLLOW, MODE_SOLID_SOLID
    };

    typedef struct {
        logic signed [COORD_W-1:0] bmin [NUM_AXES];
        logic signed [COORD_W-1:0] bmax [NUM_AXES];
        logic signed [COORD_W-1:0] ctr  [NUM_AXES];
        logic        [RADIUS_W-1:0] radius;
        logic        [MODE_W-1:0]   command;
    } t_query;

    // Scoreboard: computes the expected flag per accepted query and checks
    // result beats in order.
    class t_intersect_scoreboard;
        bit                  pending_hits [$];
        int unsigned         pending_seq [$];
        logic [RADIUS_W-1:0] margin;
        int unsigned         queries;
        int unsigned         checked;
        int unsigned         hits;
        int unsigned         mismatches;

        function new();
            margin     = '0;
            queries    = 0;
            checked    = 0;
            hits       = 0;
            mismatches = 0;
        endfunction

        function void set_margin(logic [RADIUS_W-1:0] value);
            margin = value;
        endfunction

        function int unsigned pending();
            return pending_hits.size();
        endfunction

        // Square of an exact difference, which always fits in 64 bits.
        static function logic [SQ_W-1:0] sq_mag(longint d);
            logic [SQ_W-1:0] m;
            m = (d < 0) ? SQ_W'(-d) : SQ_W'(d);
            return m * m;
        endfunction

        function bit intersects_for(t_query q);
            logic [RAD_W-1:0] r;
            logic [SQ_W-1:0]  r2;
            logic [SQ_W-1:0]  to_min;
            logic [SQ_W-1:0]  to_max;
            logic [SUM_W-1:0] inner_sum;
            logic [SUM_W-1:0] outer_sum;
            longint           c;
            longint           lo;
            longint           hi;
            bit               below;
            bit               above;
            bit               face;
            bit               inner_fits;
            bit               outer_reaches;
            r         = RAD_W'(q.radius) + RAD_W'(margin);
            r2        = SQ_W'(r) * SQ_W'(r);
            inner_sum = '0;
            outer_sum = '0;
            face      = 1'b0;
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                c      = longint'(q.ctr[ax]);
                lo     = longint'(q.bmin[ax]);
                hi     = longint'(q.bmax[ax]);
                to_min = sq_mag(c - lo);
                to_max = sq_mag(c - hi);
                below  = c < lo;
                above  = !below && c > hi;
                outer_sum += SUM_W'((to_min > to_max) ? to_min : to_max);
                if (below) begin
                    inner_sum += SUM_W'(to_min);
                    face = 1'b1;
                end else if (above) begin
                    inner_sum += SUM_W'(to_max);
                    face = 1'b1;
                end else if (q.command == MODE_HOLLOW_HOLLOW) begin
                    if (((to_min < to_max) ? to_min : to_max) <= r2) face = 1'b1;
                end else if (q.command == MODE_HOLLOW_SOLID) begin
                    // Inside the slab the hollow box compares linear gaps.
                    if (c - lo <= longint'(r) || hi - c <= longint'(r)) face = 1'b1;
                end
            end
            inner_fits    = inner_sum <= SUM_W'(r2);
            outer_reaches = SUM_W'(r2) <= outer_sum;
            case (q.command)
                MODE_HOLLOW_HOLLOW: return face && inner_fits && outer_reaches;
                MODE_HOLLOW_SOLID:  return face && inner_fits;
                MODE_SOLID_HOLLOW:  return inner_fits && outer_reaches;
                MODE_SOLID_SOLID:   return inner_fits;
                default:            return 1'b0;
            endcase
        endfunction

        function void note_query(t_query q);
            pending_hits.push_back(intersects_for(q));
            pending_seq.push_back(queries);
            queries++;
        endfunction

        function void check_flag(logic got);
            bit          want;
            int unsigned seq;
            if (pending_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_MAX)
                    $display("Mismatch: result beat %0b with no query pending", got);
                return;
            end
            want = pending_hits.pop_front();
            seq  = pending_seq.pop_front();
            checked++;
            if (want) hits++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= SHOWN_MAX)
                    $display("Mismatch: query %0d intersects expected %0b, got %0b",
                             seq, want, got);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [RADIUS_W-1:0]   cfg_wdata;
    bit                    gaps_on;
    int unsigned           rx_hold_cycles;
    int unsigned           stuck_cycles;
    t_intersect_scoreboard sb;

    bsi_in_if  q_if ();
    bsi_out_if r_if ();

    box_sphere_intersection_test u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (q_if.sink),
        .o_out       (r_if.source)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Idle lengths: mostly short, now and then long.
    function automatic int unsigned idle_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic longint span(longint u);
        return longint'($urandom_range(0, 32'(2 * u))) - u;
    endfunction

    // Same interval on all three axes, with a free center.
    function automatic t_query cube(longint lo, longint hi, longint cx, longint cy,
                                    longint cz, longint rad, logic [MODE_W-1:0] cmd);
        t_query q;
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            q.bmin[ax] = COORD_W'(lo);
            q.bmax[ax] = COORD_W'(hi);
        end
        q.ctr[0]    = COORD_W'(cx);
        q.ctr[1]    = COORD_W'(cy);
        q.ctr[2]    = COORD_W'(cz);
        q.radius    = RADIUS_W'(rad);
        q.command   = cmd;
        return q;
    endfunction

    // Random query: raw noise, a local box near its sphere, or a sphere that
    // just touches, misses or crosses one face.
    function automatic t_query rand_query();
        t_query      q;
        int unsigned kind;
        longint      unit;
        longint      base;
        longint      lo;
        longint      hi;
        longint      gap;
        int unsigned k;
        kind      = $urandom_range(0, 19);
        q.command = MODE_W'($urandom_range(0, 3));
        if (kind < 3) begin
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                q.bmin[ax] = COORD_W'($urandom());
                q.bmax[ax] = COORD_W'($urandom());
                q.ctr[ax]  = COORD_W'($urandom());
            end
            q.radius = RADIUS_W'($urandom());
            return q;
        end
        unit = longint'(1) << $urandom_range(2, 28);
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            base = longint'($signed($urandom())) >>> $urandom_range(0, 12);
            lo   = base + span(unit);
            hi   = lo + longint'($urandom_range(0, 32'(2 * unit)));
            if ($urandom_range(0, 19) == 0) begin
                gap = lo;
                lo  = hi;
                hi  = gap;
            end
            q.bmin[ax] = COORD_W'(lo);
            q.bmax[ax] = COORD_W'(hi);
            q.ctr[ax]  = COORD_W'(base + span(2 * unit));
        end
        q.radius = RADIUS_W'($urandom_range(0, 32'(2 * unit)));
        if (kind < 7) begin
            // Center beyond one face, inside the slab on the other axes.
            k   = $urandom_range(0, NUM_AXES - 1);
            gap = longint'($urandom_range(0, 32'(unit)));
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                lo = longint'(q.bmin[ax]);
                hi = longint'(q.bmax[ax]);
                q.ctr[ax] = COORD_W'(lo + (hi - lo) / 2);
            end
            lo = longint'(q.bmin[k]);
            hi = longint'(q.bmax[k]);
            q.ctr[k]  = COORD_W'($urandom_range(0, 1) ? hi + gap : lo - gap);
            q.radius  = RADIUS_W'(gap + longint'($urandom_range(0, 2)) - 1);
            if (gap == 0 && q.radius == '1) q.radius = '0;
        end
        return q;
    endfunction

    // Offer one query beat and hold it until the block takes it.
    task automatic send_query(input t_query q);
        int unsigned gap;
        gap = (gaps_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap != 0) begin
            q_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        q_if.valid     <= 1'b1;
        q_if.box_min_x <= q.bmin[0];
        q_if.box_min_y <= q.bmin[1];
        q_if.box_min_z <= q.bmin[2];
        q_if.box_max_x <= q.bmax[0];
        q_if.box_max_y <= q.bmax[1];
        q_if.box_max_z <= q.bmax[2];
        q_if.center_x  <= q.ctr[0];
        q_if.center_y  <= q.ctr[1];
        q_if.center_z  <= q.ctr[2];
        q_if.radius    <= q.radius;
        q_if.command   <= q.command;
        @(posedge i_clk);
        while (!q_if.ready) @(posedge i_clk);
    endtask

    task automatic run_random(input int unsigned count);
        repeat (count) send_query(rand_query());
    endtask

    // Wait until the pipeline is empty, then write the margin register.
    task automatic write_margin(input logic [RADIUS_W-1:0] value);
        q_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_margin(value);
    endtask

    // Result side: random ready pattern, plus a long hold-off on request.
    initial begin : result_sink
        int unsigned run_len;
        r_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                run_len        = rx_hold_cycles;
                rx_hold_cycles = 0;
                r_if.ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                run_len = idle_len();
                r_if.ready <= 1'b0;
            end else begin
                run_len = $urandom_range(1, 8);
                r_if.ready <= 1'b1;
            end
            repeat (run_len) @(posedge i_clk);
        end
    end

    // Beat monitors and the stall watchdog.
    always @(posedge i_clk) begin : beat_monitor
        t_query q;
        if (!i_rst_n) begin
            stuck_cycles = 0;
        end else begin
            if (q_if.valid && q_if.ready) begin
                q.bmin[0]  = q_if.box_min_x;
                q.bmin[1]  = q_if.box_min_y;
                q.bmin[2]  = q_if.box_min_z;
                q.bmax[0]  = q_if.box_max_x;
                q.bmax[1]  = q_if.box_max_y;
                q.bmax[2]  = q_if.box_max_z;
                q.ctr[0]   = q_if.center_x;
                q.ctr[1]   = q_if.center_y;
                q.ctr[2]   = q_if.center_z;
                q.radius   = q_if.radius;
                q.command  = q_if.command;
                sb.note_query(q);
            end
            if (r_if.valid && r_if.ready)
                sb.check_flag(r_if.intersects);
            if ((q_if.valid && q_if.ready) || (r_if.valid && r_if.ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= STALL_LIMIT) begin
                    $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
                    $display("[box_sphere_intersection_test] ERROR");
                    $finish;
                end
            end
        end
    end

    // Stimulus sequence.
    initial begin : stimulus
        sb             = new();
        gaps_on        = 1'b1;
        rx_hold_cycles = 0;
        i_rst_n        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        q_if.valid     <= 1'b0;
        q_if.box_min_x <= '0;
        q_if.box_min_y <= '0;
        q_if.box_min_z <= '0;
        q_if.box_max_x <= '0;
        q_if.box_max_y <= '0;
        q_if.box_max_z <= '0;
        q_if.center_x  <= '0;
        q_if.center_y  <= '0;
        q_if.center_z  <= '0;
        q_if.radius    <= '0;
        q_if.command   <= MODE_HOLLOW_HOLLOW;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cases with the margin at its reset value.
        foreach (ALL_MODES[m]) begin
            // Small sphere deep inside, one crossing the x face, one touching it.
            send_query(cube(0, 10 * ONE, 5 * ONE, 5 * ONE, 5 * ONE, ONE, ALL_MODES[m]));
            send_query(cube(0, 10 * ONE, 9 * ONE + ONE / 2, 5 * ONE, 5 * ONE, ONE,
                            ALL_MODES[m]));
            send_query(cube(0, 10 * ONE, 12 * ONE, 5 * ONE, 5 * ONE, 2 * ONE,
                            ALL_MODES[m]));
        end
        // Just short of touching from outside.
        send_query(cube(0, 10 * ONE, 12 * ONE, 5 * ONE, 5 * ONE, 2 * ONE - 1,
                        MODE_SOLID_SOLID));
        send_query(cube(0, 10 * ONE, 12 * ONE, 5 * ONE, 5 * ONE, 2 * ONE - 1,
                        MODE_HOLLOW_HOLLOW));
        // Hollow box, solid sphere: linear gap equal to the radius, then one short.
        send_query(cube(0, 10 * ONE, 8 * ONE, 5 * ONE, 5 * ONE, 2 * ONE,
                        MODE_HOLLOW_SOLID));
        send_query(cube(0, 10 * ONE, 8 * ONE, 5 * ONE, 5 * ONE, 2 * ONE - 1,
                        MODE_HOLLOW_SOLID));
        // Inverted box.
        send_query(cube(10 * ONE, 0, 5 * ONE, 5 * ONE, 5 * ONE, ONE, MODE_SOLID_SOLID));
        send_query(cube(10 * ONE, 0, 5 * ONE, 5 * ONE, 5 * ONE, ONE, MODE_HOLLOW_SOLID));
        // Full-range coordinates; all four overflow a 64-bit far sum, the last two the near sum too.
        send_query(cube(MIN_C, MAX_C, MIN_C, MIN_C, MIN_C, MAX_R, MODE_HOLLOW_HOLLOW));
        send_query(cube(MIN_C, MAX_C, MIN_C, MIN_C, MIN_C, MAX_R, MODE_SOLID_SOLID));
        send_query(cube(MAX_C, MAX_C, MIN_C, MIN_C, MIN_C, MAX_R, MODE_SOLID_SOLID));
        send_query(cube(MAX_C, MAX_C, MIN_C, MIN_C, MIN_C, MAX_R, MODE_SOLID_HOLLOW));
        // Zero radius sitting on a corner.
        send_query(cube(0, ONE, ONE, ONE, ONE, 0, MODE_SOLID_SOLID));
        send_query(cube(0, ONE, ONE, ONE, ONE, 0, MODE_HOLLOW_HOLLOW));

        // Random phases across margins.
        write_margin(RADIUS_W'(MAX_R));
        run_random(300);

        gaps_on = 1'b0;
        write_margin(RADIUS_W'(1));
        run_random(300);

        // Long receiver hold-off while queries keep coming.
        write_margin('0);
        rx_hold_cycles = 400;
        run_random(100);
        gaps_on = 1'b1;
        run_random(300);

        write_margin(RADIUS_W'($urandom()));
        run_random(350);

        write_margin(RADIUS_W'(ONE));
        run_random(400);

        q_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (NUM_STAGES + 4) @(posedge i_clk);

        $display("Checked %0d results (%0d hits) over all four modes,", sb.checked, sb.hits);
        $display("margins from zero to full scale, with a long output hold-off.");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[box_sphere_intersection_test] OK");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("[box_sphere_intersection_test] ERROR");
        end
        $finish;
    end

endmodule
